// ===== hdl/aoc_pkg.sv =====
// Package: shared types and constants for the accelerometer offset calibrator.
package aoc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RANGE_W  = 5;
  localparam int unsigned ITER_W   = 13;
  localparam int unsigned ERR_W    = 15;
  localparam int unsigned DIV_W    = 23;
  localparam int unsigned DCNT_W   = 5;
  localparam int unsigned ACC_W    = DIV_W + 1;
  localparam int unsigned MUL_W    = SAMPLE_W + 1;
  localparam int unsigned PROD_W   = MUL_W + RANGE_W + 1;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [DIV_W-1:0] ONE_G_NUM = DIV_W'(32768);

  localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_W'(2);
  localparam logic [ITER_W-1:0]  ITER_RST  = ITER_W'(100);
  localparam logic [ERR_W-1:0]   ERR_RST   = ERR_W'(20);

  typedef enum logic [1:0] {
    REG_ACCEL_RANGE  = 2'd0,
    REG_OFFSET_RANGE = 2'd1,
    REG_MEAN_ITER    = 2'd2,
    REG_MAX_ERROR    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    STEP_ONE_G     = 3'd0,
    STEP_ONE_G_OFF = 3'd1,
    STEP_X         = 3'd2,
    STEP_Y         = 3'd3,
    STEP_Z         = 3'd4
  } step_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_DIV   = 6'b000100,
    S_STORE = 6'b001000,
    S_ZPRE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

endpackage

// ===== hdl/accel_offset_calibrator_unit.sv =====
// Top level: accelerometer offset calibrator with a shared iterative divider.
//
// Input channel (in_valid/in_ready): one transaction is a command plus a
// three-axis sample. Command 1 restarts calibration with zero offsets and
// gives no result. Command 0 folds the sample into the per-axis halving mean.
// A sample is accepted whenever in_ready is high; samples after calibration is complete are
// dropped until a restart.
// After mean_iterations samples the block runs five divisions on one shared
// restoring divider (one quotient bit per cycle) plus load, store and setup
// states, and then presents one result on the output channel
// (out_valid/out_ready): the three offsets, per-axis status and complete.
// in_ready is low during that sequence and high otherwise.
// A result sits in the output register until taken; new samples are still
// accepted meanwhile, and a sequence that finishes while the previous result
// is stalled holds until the output register frees.
// Reset (rst_n, synchronous) clears offsets, means, count and the complete
// flag and loads the register defaults: ranges 2 g, 100 samples, error 20.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12.
module accel_offset_calibrator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [aoc_pkg::SAMPLE_W-1:0]  in_accel_x,
  input  logic signed [aoc_pkg::SAMPLE_W-1:0]  in_accel_y,
  input  logic signed [aoc_pkg::SAMPLE_W-1:0]  in_accel_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [aoc_pkg::SAMPLE_W-1:0]  out_offset_x,
  output logic signed [aoc_pkg::SAMPLE_W-1:0]  out_offset_y,
  output logic signed [aoc_pkg::SAMPLE_W-1:0]  out_offset_z,
  output logic [2:0]                           out_axes_ok,
  output logic                                 out_complete,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [aoc_pkg::ADDR_W-1:0]           paddr,
  input  logic [aoc_pkg::DATA_W-1:0]           pwdata,
  output logic [aoc_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import aoc_pkg::*;

  logic [RANGE_W-1:0] accel_range_r, offset_range_r;
  logic [ITER_W-1:0]  mean_iter_r;
  logic [ERR_W-1:0]   max_error_r;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic signed [SAMPLE_W-1:0] mean_x_r, mean_y_r, mean_z_r;
  logic signed [SAMPLE_W-1:0] mean_x_nxt, mean_y_nxt, mean_z_nxt;
  logic [ITER_W-1:0]          count_r, count_nxt;
  logic signed [SAMPLE_W-1:0] offs_x_r, offs_y_r, offs_z_r;
  logic signed [SAMPLE_W-1:0] offs_x_nxt, offs_y_nxt, offs_z_nxt;
  logic                       finished_r, finished_nxt;
  logic [2:0]                 ok_r, ok_nxt;
  logic [SAMPLE_W-1:0]        one_g_r, one_g_nxt, one_g_off_r, one_g_off_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;

  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [RANGE_W-1:0] rem_r, rem_nxt;
  logic [RANGE_W-1:0] dvsr_r, dvsr_nxt;
  logic               neg_r, neg_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0]  out_x_r, out_y_r, out_z_r;
  logic signed [SAMPLE_W-1:0]  out_x_nxt, out_y_nxt, out_z_nxt;
  logic [2:0]                  out_ok_r, out_ok_nxt;

  logic [RANGE_W-1:0] r_eff, o_eff;
  logic [ITER_W-1:0]  iter_eff;
  logic               cfg_wr, in_acc;

  logic signed [MUL_W-1:0]    mul_a;
  logic [RANGE_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    dividend;
  logic [DIV_W-1:0]           div_mag;
  logic [RANGE_W:0]           trial;
  logic                       trial_ge;
  logic signed [ACC_W-1:0]    quo_s;
  logic signed [MUL_W-1:0]    sum_x, sum_y, sum_z;
  logic signed [MUL_W-1:0]    half_x, half_y, half_z;
  logic [ITER_W-1:0]          count_inc;
  logic [MUL_W-1:0]           abs_x, abs_y;
  logic signed [MUL_W:0]      dz;
  logic [MUL_W:0]             abs_z;

  assign r_eff    = (accel_range_r == '0) ? RANGE_W'(1) : accel_range_r;
  assign o_eff    = (offset_range_r == '0) ? RANGE_W'(1) : offset_range_r;
  assign iter_eff = (mean_iter_r == '0) ? ITER_W'(1) : mean_iter_r;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_ACCEL_RANGE:  prdata = DATA_W'(accel_range_r);
      REG_OFFSET_RANGE: prdata = DATA_W'(offset_range_r);
      REG_MEAN_ITER:    prdata = DATA_W'(mean_iter_r);
      REG_MAX_ERROR:    prdata = DATA_W'(max_error_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_range_r  <= RANGE_RST;
      offset_range_r <= RANGE_RST;
      mean_iter_r    <= ITER_RST;
      max_error_r    <= ERR_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[ADDR_W-1:2]))
        REG_ACCEL_RANGE:  accel_range_r  <= pwdata[RANGE_W-1:0];
        REG_OFFSET_RANGE: offset_range_r <= pwdata[RANGE_W-1:0];
        REG_MEAN_ITER:    mean_iter_r    <= pwdata[ITER_W-1:0];
        REG_MAX_ERROR:    max_error_r    <= pwdata[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // mean update, truncated toward zero
  assign sum_x  = MUL_W'(in_accel_x) + MUL_W'(mean_x_r);
  assign sum_y  = MUL_W'(in_accel_y) + MUL_W'(mean_y_r);
  assign sum_z  = MUL_W'(in_accel_z) + MUL_W'(mean_z_r);
  assign half_x = (sum_x + MUL_W'(sum_x[MUL_W-1])) >>> 1;
  assign half_y = (sum_y + MUL_W'(sum_y[MUL_W-1])) >>> 1;
  assign half_z = (sum_z + MUL_W'(sum_z[MUL_W-1])) >>> 1;
  assign count_inc = count_r + ITER_W'(1);

  // shared multiplier
  always_comb begin
    mul_a = MUL_W'(mean_x_r);
    mul_b = r_eff;
    if (state_r == S_ZPRE) begin
      mul_a = MUL_W'(offs_z_r) + $signed({1'b0, one_g_off_r});
      mul_b = o_eff;
    end else begin
      case (step_r)
        STEP_Y:  mul_a = MUL_W'(mean_y_r);
        STEP_Z:  mul_a = MUL_W'(mean_z_r);
        default: mul_a = MUL_W'(mean_x_r);
      endcase
    end
  end
  assign prod = mul_a * $signed({1'b0, mul_b});

  always_comb begin
    case (step_r)
      STEP_ONE_G, STEP_ONE_G_OFF: dividend = $signed({1'b0, ONE_G_NUM});
      STEP_Z:  dividend = acc_r - ACC_W'(prod);
      default: dividend = ACC_W'(prod);
    endcase
  end
  assign div_mag = dividend[ACC_W-1] ? DIV_W'(-dividend) : dividend[DIV_W-1:0];

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, dvsr_r});
  assign quo_s    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  assign abs_x = mean_x_r[SAMPLE_W-1] ? MUL_W'(-MUL_W'(mean_x_r)) : MUL_W'(mean_x_r);
  assign abs_y = mean_y_r[SAMPLE_W-1] ? MUL_W'(-MUL_W'(mean_y_r)) : MUL_W'(mean_y_r);
  assign dz    = (MUL_W+1)'(mean_z_r) - $signed({2'b00, one_g_r});
  assign abs_z = dz[MUL_W] ? (MUL_W+1)'(-dz) : dz;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mean_x_nxt    = mean_x_r;
    mean_y_nxt    = mean_y_r;
    mean_z_nxt    = mean_z_r;
    count_nxt     = count_r;
    offs_x_nxt    = offs_x_r;
    offs_y_nxt    = offs_y_r;
    offs_z_nxt    = offs_z_r;
    finished_nxt  = finished_r;
    ok_nxt        = ok_r;
    one_g_nxt     = one_g_r;
    one_g_off_nxt = one_g_off_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvsr_nxt      = dvsr_r;
    neg_nxt       = neg_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_ok_nxt    = out_ok_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_command) begin
            offs_x_nxt   = '0;
            offs_y_nxt   = '0;
            offs_z_nxt   = '0;
            mean_x_nxt   = '0;
            mean_y_nxt   = '0;
            mean_z_nxt   = '0;
            count_nxt    = '0;
            finished_nxt = 1'b0;
          end else if (!finished_r) begin
            mean_x_nxt = half_x[SAMPLE_W-1:0];
            mean_y_nxt = half_y[SAMPLE_W-1:0];
            mean_z_nxt = half_z[SAMPLE_W-1:0];
            count_nxt  = count_inc;
            if (count_inc >= iter_eff) begin
              state_nxt = S_LOAD;
              step_nxt  = STEP_ONE_G;
              ok_nxt    = '0;
            end
          end
        end
      end
      S_LOAD: begin
        quo_nxt  = div_mag;
        neg_nxt  = dividend[ACC_W-1];
        rem_nxt  = '0;
        dcnt_nxt = '0;
        dvsr_nxt = (step_r == STEP_ONE_G) ? r_eff : o_eff;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = trial_ge ? RANGE_W'(trial - {1'b0, dvsr_r}) : trial[RANGE_W-1:0];
        quo_nxt  = {quo_r[DIV_W-2:0], trial_ge};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_W - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        case (step_r)
          STEP_ONE_G:     one_g_nxt     = quo_r[SAMPLE_W-1:0];
          STEP_ONE_G_OFF: one_g_off_nxt = quo_r[SAMPLE_W-1:0];
          STEP_X: begin
            if (abs_x > MUL_W'(max_error_r)) begin
              offs_x_nxt = offs_x_r - quo_s[SAMPLE_W-1:0];
            end else begin
              ok_nxt[0] = 1'b1;
            end
          end
          STEP_Y: begin
            if (abs_y > MUL_W'(max_error_r)) begin
              offs_y_nxt = offs_y_r - quo_s[SAMPLE_W-1:0];
            end else begin
              ok_nxt[1] = 1'b1;
            end
          end
          STEP_Z: begin
            if (abs_z > (MUL_W+1)'(max_error_r)) begin
              offs_z_nxt = quo_s[SAMPLE_W-1:0];
            end else begin
              ok_nxt[2] = 1'b1;
            end
          end
          default: ;
        endcase
        case (step_r)
          STEP_ONE_G:     begin step_nxt = STEP_ONE_G_OFF; state_nxt = S_LOAD; end
          STEP_ONE_G_OFF: begin step_nxt = STEP_X;         state_nxt = S_LOAD; end
          STEP_X:         begin step_nxt = STEP_Y;         state_nxt = S_LOAD; end
          STEP_Y:         begin step_nxt = STEP_Z;         state_nxt = S_ZPRE; end
          default:        state_nxt = S_OUT;
        endcase
      end
      S_ZPRE: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = S_LOAD;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = offs_x_r;
          out_y_nxt     = offs_y_r;
          out_z_nxt     = offs_z_r;
          out_ok_nxt    = ok_r;
          mean_x_nxt    = '0;
          mean_y_nxt    = '0;
          mean_z_nxt    = '0;
          count_nxt     = '0;
          finished_nxt  = (ok_r == 3'b111);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_ONE_G;
      mean_x_r    <= '0;
      mean_y_r    <= '0;
      mean_z_r    <= '0;
      count_r     <= '0;
      offs_x_r    <= '0;
      offs_y_r    <= '0;
      offs_z_r    <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mean_x_r    <= mean_x_nxt;
      mean_y_r    <= mean_y_nxt;
      mean_z_r    <= mean_z_nxt;
      count_r     <= count_nxt;
      offs_x_r    <= offs_x_nxt;
      offs_y_r    <= offs_y_nxt;
      offs_z_r    <= offs_z_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r        <= ok_nxt;
    one_g_r     <= one_g_nxt;
    one_g_off_r <= one_g_off_nxt;
    acc_r       <= acc_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dvsr_r      <= dvsr_nxt;
    neg_r       <= neg_nxt;
    dcnt_r      <= dcnt_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_z_r     <= out_z_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_offset_x = out_x_r;
  assign out_offset_y = out_y_r;
  assign out_offset_z = out_z_r;
  assign out_axes_ok  = out_ok_r;
  assign out_complete = (out_ok_r == 3'b111);

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=> (count_r == '0) && !finished_r)
    else $error("restart did not clear count and finished flag");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input accepted during adjustment sequence");

  a_finished_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command && finished_r |=> (state_r == S_IDLE))
    else $error("sample processed while calibration complete");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && (!out_valid_r || out_ready) |=>
      out_valid_r && (finished_r == (out_ok_r == 3'b111)) && (count_r == '0))
    else $error("result load inconsistent with finished flag");

endmodule

// ===== tb/tb_accel_offset_calibrator_unit.sv =====
// Self-checking testbench for the accelerometer offset calibrator: predicted offsets vs. results.
module tb_accel_offset_calibrator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import aoc_pkg::*;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam int   STALL_CYCLES = 600;
  localparam int   DRAIN_CYCLES = 200;
  localparam int   CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ox;
    logic signed [SAMPLE_W-1:0] oy;
    logic signed [SAMPLE_W-1:0] oz;
    logic [2:0]                 ok;
    logic                       done;
  } calib_result_t;

  class offset_checker;
    logic [RANGE_W-1:0]         accel_rng = RANGE_RST;
    logic [RANGE_W-1:0]         offs_rng  = RANGE_RST;
    logic [ITER_W-1:0]          mean_iter = ITER_RST;
    logic [ERR_W-1:0]           max_err   = ERR_RST;
    int                         mean_x, mean_y, mean_z;
    logic [ITER_W-1:0]          samples_taken = '0;
    logic signed [SAMPLE_W-1:0] offs_x = '0, offs_y = '0, offs_z = '0;
    bit                         done_flag;
    calib_result_t              expected_offsets[$];
    int                         errors, checked;

    function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_ACCEL_RANGE:  accel_rng = val[RANGE_W-1:0];
        REG_OFFSET_RANGE: offs_rng  = val[RANGE_W-1:0];
        REG_MEAN_ITER:    mean_iter = val[ITER_W-1:0];
        REG_MAX_ERROR:    max_err   = val[ERR_W-1:0];
        default: ;
      endcase
    endfunction

    function int one_g();
      return 32768 / ((accel_rng == 0) ? 1 : int'(accel_rng));
    endfunction

    function int iabs(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Returns 0 when the transaction is dropped because calibration is complete.
    function bit note_input(logic cmd, logic signed [SAMPLE_W-1:0] ax,
                            logic signed [SAMPLE_W-1:0] ay, logic signed [SAMPLE_W-1:0] az);
      int r, o, tol, g_off, num;
      logic [2:0] ok;
      if (cmd == CMD_RESTART) begin
        offs_x = '0; offs_y = '0; offs_z = '0;
        mean_x = 0; mean_y = 0; mean_z = 0;
        samples_taken = '0;
        done_flag = 1'b0;
        return 1'b1;
      end
      if (done_flag) return 1'b0;
      mean_x = (int'(ax) + mean_x) / 2;
      mean_y = (int'(ay) + mean_y) / 2;
      mean_z = (int'(az) + mean_z) / 2;
      samples_taken = samples_taken + 1'b1;
      if (int'(samples_taken) < ((mean_iter == 0) ? 1 : int'(mean_iter))) return 1'b1;
      r   = (accel_rng == 0) ? 1 : int'(accel_rng);
      o   = (offs_rng == 0) ? 1 : int'(offs_rng);
      tol = int'(max_err);
      ok  = '0;
      if (iabs(mean_x) > tol) offs_x = SAMPLE_W'(int'(offs_x) - (mean_x * r) / o);
      else ok[0] = 1'b1;
      if (iabs(mean_y) > tol) offs_y = SAMPLE_W'(int'(offs_y) - (mean_y * r) / o);
      else ok[1] = 1'b1;
      g_off = 32768 / o;
      if (iabs(mean_z - one_g()) > tol) begin
        num    = (int'(offs_z) + g_off) * o - mean_z * r;
        offs_z = SAMPLE_W'(num / o);
      end else begin
        ok[2] = 1'b1;
      end
      mean_x = 0; mean_y = 0; mean_z = 0;
      samples_taken = '0;
      done_flag = (ok == 3'b111);
      expected_offsets.push_back('{offs_x, offs_y, offs_z, ok, done_flag});
      return 1'b1;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(calib_result_t got);
      calib_result_t want;
      if (expected_offsets.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %p", $time, got);
        return;
      end
      want = expected_offsets.pop_front();
      checked++;
      compare_field("offset_x", int'(want.ox), int'(got.ox));
      compare_field("offset_y", int'(want.oy), int'(got.oy));
      compare_field("offset_z", int'(want.oz), int'(got.oz));
      compare_field("axes_ok", int'(want.ok), int'(got.ok));
      compare_field("complete", int'(want.done), int'(got.done));
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_command;
  logic signed [SAMPLE_W-1:0] in_accel_x, in_accel_y, in_accel_z;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_offset_x, out_offset_y, out_offset_z;
  logic [2:0]                 out_axes_ok;
  logic                       out_complete;
  logic                       psel, penable, pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  offset_checker calib = new;
  int send_idle_pct, recv_idle_pct;
  int hold_request, hold_taken, hold_left;
  int live_items, ignored_items, settings_used;
  int cycles;

  accel_offset_calibrator_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_accel_x   (in_accel_x),
    .in_accel_y   (in_accel_y),
    .in_accel_z   (in_accel_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_offset_x (out_offset_x),
    .out_offset_y (out_offset_y),
    .out_offset_z (out_offset_z),
    .out_axes_ok  (out_axes_ok),
    .out_complete (out_complete),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_request != hold_taken) begin
      hold_taken = hold_request;
      hold_left  = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      calib.check_result('{out_offset_x, out_offset_y, out_offset_z, out_axes_ok, out_complete});
  end

  function automatic logic signed [SAMPLE_W-1:0] steer(int target, int mean, int span);
    int v;
    v = 2 * target - mean + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  task automatic drive_item(input logic cmd, input logic signed [SAMPLE_W-1:0] ax,
                            input logic signed [SAMPLE_W-1:0] ay,
                            input logic signed [SAMPLE_W-1:0] az);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_command = cmd;
    in_accel_x = ax;
    in_accel_y = ay;
    in_accel_z = az;
    do @(posedge clk); while (!in_ready);
    if (calib.note_input(cmd, ax, ay, az)) live_items++;
    else ignored_items++;
    @(negedge clk);
  endtask

  task automatic next_item(input int span);
    int k;
    k = $urandom_range(0, 99);
    if (calib.done_flag ? (k < 30) : (k < 3))
      drive_item(CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
    else if (k < 65)
      drive_item(CMD_SAMPLE, steer(0, calib.mean_x, span), steer(0, calib.mean_y, span),
                 steer(calib.one_g(), calib.mean_z, span));
    else if (k < 92)
      drive_item(CMD_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
    else
      drive_item(CMD_SAMPLE, pick_extreme(), pick_extreme(), pick_extreme());
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    calib.write_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (calib.expected_offsets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input int ar, input int orng, input int iters, input int merr);
    reg_write(REG_ACCEL_RANGE, DATA_W'(ar));
    reg_write(REG_OFFSET_RANGE, DATA_W'(orng));
    reg_write(REG_MEAN_ITER, DATA_W'(iters));
    reg_write(REG_MAX_ERROR, DATA_W'(merr));
    settings_used++;
  endtask

  task automatic run_phase(input int ar, input int orng, input int iters, input int merr,
                           input int n_items, input int sidle, input int ridle,
                           input bit stall);
    int stop_at;
    configure(ar, orng, iters, merr);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    if (stall) hold_request++;
    stop_at = live_items + ignored_items + n_items;
    while (live_items + ignored_items < stop_at) next_item(merr + 1);
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_SAMPLE;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    send_idle_pct = 38;
    recv_idle_pct = 52;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    repeat (3) drive_item(CMD_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    configure(2, 2, 0, 20);
    drive_item(CMD_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    drive_item(CMD_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
    drive_item(CMD_SAMPLE, 16'sh0000, 16'sh0000, 16'sh0000);
    drive_item(CMD_SAMPLE, 16'shffff, 16'shffff, 16'shffff);
    drive_item(CMD_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh0000);
    drive_item(CMD_RESTART, 16'sh7fff, 16'sh8000, 16'shffff);
    repeat (3)
      drive_item(CMD_SAMPLE, steer(0, calib.mean_x, 0), steer(0, calib.mean_y, 0),
                 steer(calib.one_g(), calib.mean_z, 0));
    drive_item(CMD_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh8000);
    drive_item(CMD_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh7fff);
    drive_item(CMD_RESTART, 16'sh0000, 16'sh0000, 16'sh0000);
    drive_item(CMD_SAMPLE, 16'sh8000, 16'sh0000, 16'sh0000);
    drive_item(CMD_SAMPLE, 16'sh0000, 16'sh7fff, 16'sh8000);
    drain();

    run_phase(4, 2, 1, 100, 150, 38, 52, 1'b1);
    run_phase(31, 1, 3, 0, 150, 38, 52, 1'b0);
    run_phase(0, 0, 8191, 32767, 40, 38, 52, 1'b0);
    run_phase(16, 16, 8, 500, 250, 52, 38, 1'b0);
    run_phase(8, 31, 2, 5, 200, 52, 38, 1'b0);
    run_phase(2, 2, 16, 20, 150, 0, 0, 1'b0);
    run_phase(5, 3, 1, 32767, 150, 0, 0, 1'b0);

    $display("Sent %0d transactions (%0d more dropped while complete) over %0d register settings",
             live_items, ignored_items, settings_used);
    $display("Checked %0d calibration results, %0d mismatches", calib.checked, calib.errors);
    if (calib.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/aoc_pkg.sv
hdl/accel_offset_calibrator_unit.sv
tb/tb_accel_offset_calibrator_unit.sv
